FILE: src/gsrd_pkg.sv
// ============================================================================
// gsrd_pkg
// Shared types and constants for the gas sensor reply decoder: frame layout,
// field widths, compensation constants and the status words between units.
// ============================================================================
`default_nettype none

package gsrd_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 9;
    localparam int IDX_W       = 4;
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_HEADER = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_VAL_HI = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_VAL_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_GAS    = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_DEC    = IDX_W'(5);

    // Decimal codes carried in byte 5
    localparam logic [7:0] DEC_TENTHS     = 8'd1;
    localparam logic [7:0] DEC_HUNDREDTHS = 8'd2;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int TEMP_W    = 15;
    localparam int VALUE_W   = 16;
    localparam int RAW_W     = 23;
    localparam int TX_W      = 18;   // temperature arithmetic width
    localparam int OFF_W     = 14;   // offset numerator, at most 8000
    localparam int DEN_W     = 17;   // 90000 + 5t, at most 110000
    localparam int P1_W      = 49;   // 4e7 * raw
    localparam int P2_W      = OFF_W + DEN_W;
    localparam int DIVISOR_W = 26;   // 400 * den, at most 44e6
    localparam int NUM_W     = 48;   // non-negative numerator
    localparam int Q_W       = 23;
    localparam int CNT_W     = $clog2(Q_W);

    // Compensation constants
    localparam logic [25:0] PPM_SCALE = 26'd40000000;
    localparam logic [8:0]  DIV_SCALE = 9'd400;
    localparam logic signed [TX_W-1:0] DEN_BASE   = 18'sd90000;
    localparam logic signed [TX_W-1:0] T_LOW      = -18'sd2000;
    localparam logic signed [TX_W-1:0] T_ZERO     = 18'sd0;
    localparam logic signed [TX_W-1:0] T_MID      = 18'sd2000;
    localparam logic signed [TX_W-1:0] T_HIGH     = 18'sd4000;
    localparam logic signed [TX_W-1:0] OFF_BASE   = 18'sd200;
    localparam logic signed [TX_W-1:0] OFF_HOT    = 18'sd4000;

    // Decoded frame status from the byte parser
    typedef struct packed {
        logic               last;
        logic               check_ok;
        logic [BYTE_W-1:0]  gas;
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]  decimal;
    } frame_info_t;

    // Divider status
    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: src/gsrd_in_if.sv
// ============================================================================
// gsrd_in_if
// Byte channel into the decoder: one reply byte with temperature and frame mark.
// ============================================================================
`default_nettype none

interface gsrd_in_if import gsrd_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [BYTE_W-1:0]        rx_byte;
    logic signed [TEMP_W-1:0] temperature;
    logic                     frame_start;

    modport source (output valid, output rx_byte, output temperature,
                    output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input temperature,
                    input frame_start, output ready);

endinterface

`default_nettype wire

FILE: src/gsrd_out_if.sv
// ============================================================================
// gsrd_out_if
// Result channel out of the decoder: one decoded reading per frame.
// ============================================================================
`default_nettype none

interface gsrd_out_if import gsrd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              check_ok;
    logic [BYTE_W-1:0] gas_kind;
    logic [RAW_W-1:0]  raw_hundredths;
    logic [RAW_W-1:0]  compensated_hundredths;

    modport source (output valid, output check_ok, output gas_kind,
                    output raw_hundredths, output compensated_hundredths,
                    input ready);
    modport sink   (input valid, input check_ok, input gas_kind,
                    input raw_hundredths, input compensated_hundredths,
                    output ready);

endinterface

`default_nettype wire

FILE: src/gsrd_parser.sv
// ============================================================================
// gsrd_parser
// Byte position tracking, checksum accumulation and capture of the value,
// gas and decimal fields of the sensor reply.
// ============================================================================
`default_nettype none

module gsrd_parser import gsrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              frame_start,
    output frame_info_t            info
);

    logic [IDX_W-1:0]   byte_index_reg, byte_index_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [BYTE_W-1:0]  gas_reg, gas_next;
    logic [BYTE_W-1:0]  dec_reg, dec_next;
    logic [IDX_W-1:0]   idx;
    logic               last;

    // frame_start forces the byte to be the header
    assign idx  = frame_start ? IDX_HEADER : byte_index_reg;
    assign last = (idx >= IDX_LAST);

    always_comb
    begin
        byte_index_next = byte_index_reg;
        sum_next        = sum_reg;
        value_next      = value_reg;
        gas_next        = gas_reg;
        dec_next        = dec_reg;
        if (accept)
        begin
            byte_index_next = last ? IDX_HEADER : idx + IDX_W'(1);
            if (idx == IDX_HEADER)
            begin
                sum_next = '0;
            end
            else if (!last)
            begin
                sum_next = sum_reg + rx_byte;
                case (idx)
                    IDX_VAL_HI: value_next = {rx_byte, value_reg[BYTE_W-1:0]};
                    IDX_VAL_LO: value_next = {value_reg[VALUE_W-1:BYTE_W], rx_byte};
                    IDX_GAS:    gas_next   = rx_byte;
                    IDX_DEC:    dec_next   = rx_byte;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            sum_reg        <= '0;
            value_reg      <= '0;
            gas_reg        <= '0;
            dec_reg        <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            sum_reg        <= sum_next;
            value_reg      <= value_next;
            gas_reg        <= gas_next;
            dec_reg        <= dec_next;
        end
    end

    always_comb
    begin
        info.last     = last;
        info.check_ok = ((BYTE_W'(0) - sum_reg) == rx_byte);
        info.gas      = gas_reg;
        info.value    = value_reg;
        info.decimal  = dec_reg;
    end

endmodule

`default_nettype wire

FILE: src/gsrd_divider.sv
// ============================================================================
// gsrd_divider
// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2^Q_W so that the quotient fits in Q_W bits.
// ============================================================================
`default_nettype none

module gsrd_divider import gsrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output div_stat_t                 stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]       quo_reg, quo_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIVISOR_W+1:0] trial;

    // shift in the next dividend bit and try the subtraction
    assign trial = {1'b0, rem_reg, quo_reg[Q_W-1]} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W - 1);
            rem_next  = DIVISOR_W'(dividend[NUM_W-1:Q_W]);
            quo_next  = dividend[Q_W-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVISOR_W+1])
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[DIVISOR_W-2:0], quo_reg[Q_W-1]};
            end
            quo_next = {quo_reg[Q_W-2:0], ~trial[DIVISOR_W+1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/gas_sensor_reply_decoder_unit.sv
// ============================================================================
// gas_sensor_reply_decoder_unit
// Decodes a 9-byte gas sensor reply and gives checksum verdict, gas code,
// raw and temperature-compensated concentration in hundredths of a ppm.
//
// Channels: rx takes one reply byte per word, with the ambient temperature
// (used only with the last byte) and a frame_start mark that resyncs the
// byte counter to the header. result gives one word per complete frame.
// Bytes 0 to 7 are taken whenever rx is ready. The last byte starts the
// compensation sequence: band select, multiply and subtract in S_PREP,
// S_MULT and S_SUB, loading the restoring divider, the divide in it, one
// quotient bit per cycle, taking the quotient in S_DIV and loading the
// output register in S_DONE. rx is not ready from the last byte until
// the output register is loaded, and the result is valid once that load
// is done. A frame whose temperature is out of band or whose numerator
// is negative skips the divider and goes from S_SUB to S_DONE.
// The output register holds a finished word while the receiver stalls;
// the next frame's bytes are still taken, and only that frame's final
// load waits for the register to drain.
// Reset clears the byte counter, the checksum and the captured fields to
// zero and empties the output register.
// ============================================================================
`default_nettype none

module gas_sensor_reply_decoder_unit import gsrd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    gsrd_in_if.sink   rx,
    gsrd_out_if.source result
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MULT = 6'b000100,
        S_SUB  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    frame_info_t info;
    div_stat_t   div_stat;
    logic        accept;
    logic        div_start;
    logic        div_go_reg, div_go_next;
    logic        load;

    logic                     check_reg, check_next;
    logic [BYTE_W-1:0]        gas_reg, gas_next;
    logic [RAW_W-1:0]         raw_reg, raw_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic                     band_ok_reg, band_ok_next;
    logic [OFF_W-1:0]         off_reg, off_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [P1_W-1:0]          p1_reg, p1_next;
    logic [P2_W-1:0]          p2_reg, p2_next;
    logic [DIVISOR_W-1:0]     dsr_reg, dsr_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [RAW_W-1:0]         comp_reg, comp_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_check_reg;
    logic [BYTE_W-1:0]        out_gas_reg;
    logic [RAW_W-1:0]         out_raw_reg;
    logic [RAW_W-1:0]         out_comp_reg;

    logic signed [TX_W-1:0]   t_ext;
    logic signed [TX_W-1:0]   off_s;
    logic signed [TX_W-1:0]   den_s;
    logic [P1_W:0]            diff;

    assign rx.ready = (state_reg == S_IDLE);
    assign accept   = rx.valid && rx.ready;

    // divider start is div_go_reg, so it loads from num_reg in the cycle after S_SUB
    assign div_start = div_go_reg;

    gsrd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx.rx_byte),
        .frame_start (rx.frame_start),
        .info        (info)
    );

    gsrd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (dsr_reg),
        .stat     (div_stat)
    );

    // temperature band, offset numerator and denominator
    always_comb
    begin
        t_ext = TX_W'(temp_reg);
        if (t_ext <= T_ZERO)
        begin
            off_s = OFF_BASE - t_ext;
        end
        else if (t_ext <= T_MID)
        begin
            off_s = (t_ext <<< 1) + OFF_BASE;
        end
        else
        begin
            off_s = t_ext + OFF_HOT;
        end
        den_s = DEN_BASE + (t_ext <<< 2) + t_ext;
    end

    assign diff = {1'b0, p1_reg} - (P1_W+1)'(p2_reg);

    always_comb
    begin
        state_next   = state_reg;
        check_next   = check_reg;
        gas_next     = gas_reg;
        raw_next     = raw_reg;
        temp_next    = temp_reg;
        band_ok_next = band_ok_reg;
        off_next     = off_reg;
        den_next     = den_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        dsr_next     = dsr_reg;
        num_next     = num_reg;
        comp_next    = comp_reg;
        div_go_next  = 1'b0;
        load         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && info.last)
                begin
                    check_next = info.check_ok;
                    gas_next   = info.gas;
                    temp_next  = rx.temperature;
                    if (info.decimal == DEC_TENTHS)
                    begin
                        raw_next = RAW_W'(info.value) * RAW_W'(10);
                    end
                    else if (info.decimal == DEC_HUNDREDTHS)
                    begin
                        raw_next = RAW_W'(info.value);
                    end
                    else
                    begin
                        raw_next = RAW_W'(info.value) * RAW_W'(100);
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                band_ok_next = (t_ext > T_LOW) && (t_ext <= T_HIGH);
                off_next     = off_s[OFF_W-1:0];
                den_next     = den_s[DEN_W-1:0];
                state_next   = S_MULT;
            end
            S_MULT:
            begin
                p1_next    = P1_W'(PPM_SCALE) * P1_W'(raw_reg);
                p2_next    = P2_W'(off_reg) * P2_W'(den_reg);
                dsr_next   = DIVISOR_W'(DIV_SCALE) * DIVISOR_W'(den_reg);
                state_next = S_SUB;
            end
            S_SUB:
            begin
                num_next = diff[NUM_W-1:0];
                // out of band or negative numerator: result is zero
                if (!band_ok_reg || diff[P1_W])
                begin
                    comp_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    div_go_next = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    comp_next  = div_stat.quotient;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_go_reg    <= div_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        check_reg   <= check_next;
        gas_reg     <= gas_next;
        raw_reg     <= raw_next;
        temp_reg    <= temp_next;
        band_ok_reg <= band_ok_next;
        off_reg     <= off_next;
        den_reg     <= den_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        dsr_reg     <= dsr_next;
        num_reg     <= num_next;
        comp_reg    <= comp_next;
        if (load)
        begin
            out_check_reg <= check_reg;
            out_gas_reg   <= gas_reg;
            out_raw_reg   <= raw_reg;
            out_comp_reg  <= comp_next;
        end
    end

    assign result.valid                  = out_valid_reg;
    assign result.check_ok               = out_check_reg;
    assign result.gas_kind               = out_gas_reg;
    assign result.raw_hundredths         = out_raw_reg;
    assign result.compensated_hundredths = out_comp_reg;

    // The last byte of a frame blocks the byte channel on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && info.last) |=> !rx.ready)
        else $error("byte channel open during compensation");

    // Quotient only arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    // Compensation never exceeds 1.25 times the raw value
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ({1'b0, result.compensated_hundredths} <=
            ({1'b0, result.raw_hundredths} + (RAW_W+1)'(result.raw_hundredths[RAW_W-1:2]))))
        else $error("compensated value out of bound");

endmodule

`default_nettype wire
